/* sv/bmpu_pkg.sv */
package bmpu_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int DIM_W     = 13;
   localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int IDX_W     = 24;
   localparam int IDX_FULL_W = ROW_W + COL_W + 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int RSP_DATA_W = IDX_W + 32;

   localparam int FMT_MASK_BIT = 0;
   localparam int FMT_WIDE_BIT = 1;

   localparam logic [1:0]  FMT_RESET    = 2'd2;
   localparam logic [31:0] MASK_BYTE3   = 32'hff00_0000;
   localparam logic [31:0] MASK_BYTE2   = 32'h00ff_0000;
   localparam logic [31:0] MASK_BYTE1   = 32'h0000_ff00;
   localparam logic [31:0] MASK_BYTE0   = 32'h0000_00ff;
   localparam logic [7:0]  CHAN_ABSENT  = 8'hff;

   localparam logic [1:0] SEL_BLUE  = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_RED   = 2'd2;
   localparam logic [1:0] SEL_ALPHA = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PIXEL_FORMAT = 4'd0,
      REG_RED_MASK     = 4'd1,
      REG_GREEN_MASK   = 4'd2,
      REG_BLUE_MASK    = 4'd3,
      REG_ALPHA_MASK   = 4'd4,
      REG_IMAGE_WIDTH  = 4'd5,
      REG_IMAGE_HEIGHT = 4'd6,
      REG_TOP_DOWN     = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic       present;
      logic [1:0] sel;
   } chan_sel_type;

   typedef struct packed {
      logic             wide;
      logic             top_down;
      logic [COL_W:0]   width;
      logic [COL_W-1:0] width_m1;
      logic [ROW_W-1:0] height_m1;
      chan_sel_type     red;
      chan_sel_type     green;
      chan_sel_type     blue;
      chan_sel_type     alpha;
   } cfg_type;

   typedef struct packed {
      logic [3:0][7:0]  bytes;
      logic [ROW_W-1:0] dest_row;
      logic [COL_W-1:0] col;
      logic             last;
   } entry_type;

   function automatic chan_sel_type mask_sel(input logic [31:0] mask);
      chan_sel_type s;
      s.present = 1'b1;
      s.sel     = SEL_BLUE;
      case (mask)
         MASK_BYTE3: s.sel = SEL_ALPHA;
         MASK_BYTE2: s.sel = SEL_RED;
         MASK_BYTE1: s.sel = SEL_GREEN;
         MASK_BYTE0: s.sel = SEL_BLUE;
         default:    s.present = 1'b0;
      endcase
      return s;
   endfunction

   function automatic chan_sel_type fixed_sel(input logic [1:0] sel);
      chan_sel_type s;
      s.present = 1'b1;
      s.sel     = sel;
      return s;
   endfunction

endpackage

/* sv/bmpu_csr.sv */
module bmpu_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bmpu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmpu_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            restart,
   output bmpu_pkg::cfg_type               cfg
);
   import bmpu_pkg::*;

   logic [1:0]       format_ff;
   logic [31:0]      red_mask_ff;
   logic [31:0]      green_mask_ff;
   logic [31:0]      blue_mask_ff;
   logic [31:0]      alpha_mask_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic             top_down_ff;
   logic             wr;
   logic             wide;
   logic             masked;
   logic [COL_W:0]   width_c;
   logic [ROW_W:0]   height_c;
   chan_sel_type     red_s;
   chan_sel_type     green_s;
   chan_sel_type     blue_s;
   chan_sel_type     alpha_s;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      restart = 1'b0;
      if (wr) begin
         case (csr_index)
            REG_PIXEL_FORMAT, REG_RED_MASK, REG_GREEN_MASK, REG_BLUE_MASK,
            REG_ALPHA_MASK, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_TOP_DOWN: begin
               restart = 1'b1;
            end
            default: restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff     <= FMT_RESET;
         red_mask_ff   <= MASK_BYTE2;
         green_mask_ff <= MASK_BYTE1;
         blue_mask_ff  <= MASK_BYTE0;
         alpha_mask_ff <= '0;
         width_ff      <= DIM_W'(1);
         height_ff     <= DIM_W'(1);
         top_down_ff   <= 1'b0;
      end else begin
         if (wr) begin
            case (csr_index)
               REG_PIXEL_FORMAT: format_ff     <= csr_data[1:0];
               REG_RED_MASK:     red_mask_ff   <= csr_data;
               REG_GREEN_MASK:   green_mask_ff <= csr_data;
               REG_BLUE_MASK:    blue_mask_ff  <= csr_data;
               REG_ALPHA_MASK:   alpha_mask_ff <= csr_data;
               REG_IMAGE_WIDTH:  width_ff      <= csr_data[DIM_W-1:0];
               REG_IMAGE_HEIGHT: height_ff     <= csr_data[DIM_W-1:0];
               REG_TOP_DOWN:     top_down_ff   <= csr_data[0];
               default:          ;
            endcase
         end
      end
   end

   assign wide   = format_ff[FMT_WIDE_BIT];
   assign masked = format_ff[FMT_MASK_BIT];

   always_comb begin
      if (width_ff == '0)
         width_c = (COL_W+1)'(1);
      else if (32'(width_ff) > MAX_WIDTH)
         width_c = (COL_W+1)'(MAX_WIDTH);
      else
         width_c = (COL_W+1)'(width_ff);
      if (height_ff == '0)
         height_c = (ROW_W+1)'(1);
      else if (32'(height_ff) > MAX_HEIGHT)
         height_c = (ROW_W+1)'(MAX_HEIGHT);
      else
         height_c = (ROW_W+1)'(height_ff);
   end

   always_comb begin
      if (masked) begin
         red_s   = mask_sel(red_mask_ff);
         green_s = mask_sel(green_mask_ff);
         blue_s  = mask_sel(blue_mask_ff);
         alpha_s = mask_sel(alpha_mask_ff);
      end else begin
         red_s   = fixed_sel(SEL_RED);
         green_s = fixed_sel(SEL_GREEN);
         blue_s  = fixed_sel(SEL_BLUE);
         alpha_s = fixed_sel(SEL_ALPHA);
         alpha_s.present = wide;
      end
      // drop the fourth byte at 24 bpp
      if (!wide && red_s.sel == SEL_ALPHA)   red_s.present   = 1'b0;
      if (!wide && green_s.sel == SEL_ALPHA) green_s.present = 1'b0;
      if (!wide && blue_s.sel == SEL_ALPHA)  blue_s.present  = 1'b0;
      if (!wide && alpha_s.sel == SEL_ALPHA) alpha_s.present = 1'b0;
   end

   always_comb begin
      cfg.wide      = wide;
      cfg.top_down  = top_down_ff;
      cfg.width     = width_c;
      cfg.width_m1  = COL_W'(width_c - (COL_W+1)'(1));
      cfg.height_m1 = ROW_W'(height_c - (ROW_W+1)'(1));
      cfg.red       = red_s;
      cfg.green     = green_s;
      cfg.blue      = blue_s;
      cfg.alpha     = alpha_s;
   end

endmodule

/* sv/bmpu_front.sv */
module bmpu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                restart,
   input  bmpu_pkg::cfg_type   cfg,
   input  logic                full,
   output logic                push,
   output bmpu_pkg::entry_type push_data
);
   import bmpu_pkg::*;

   logic [1:0]       byte_ff, byte_in;
   logic [1:0]       pad_ff, pad_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [3:0][7:0]  bytes_ff, bytes_in;
   logic             take;
   logic             complete;
   logic [1:0]       last_byte;

   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;
   assign last_byte  = cfg.wide ? 2'd3 : 2'd2;
   assign complete   = take && (pad_ff == '0) && (byte_ff >= last_byte);

   always_comb begin
      byte_in  = byte_ff;
      pad_in   = pad_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      bytes_in = bytes_ff;
      if (take) begin
         if (pad_ff != '0) begin
            pad_in = pad_ff - 2'd1;
         end else begin
            bytes_in[byte_ff] = req_tdata;
            if (!complete) begin
               byte_in = byte_ff + 2'd1;
            end else begin
               byte_in = '0;
               if (col_ff != cfg.width_m1) begin
                  col_in = col_ff + COL_W'(1);
               end else begin
                  col_in = '0;
                  pad_in = cfg.wide ? 2'd0 : cfg.width[1:0];
                  row_in = (row_ff != cfg.height_m1) ? row_ff + ROW_W'(1) : '0;
               end
            end
         end
      end
      if (restart) begin
         byte_in = '0;
         pad_in  = '0;
         col_in  = '0;
         row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff  <= '0;
         pad_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         bytes_ff <= '0;
      end else begin
         byte_ff  <= byte_in;
         pad_ff   <= pad_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         bytes_ff <= bytes_in;
      end
   end

   assign push = complete;

   always_comb begin
      push_data.bytes    = bytes_in;
      push_data.col      = col_ff;
      push_data.dest_row = cfg.top_down ? row_ff : cfg.height_m1 - row_ff;
      push_data.last     = (row_ff == cfg.height_m1) && (col_ff == cfg.width_m1);
   end

endmodule

/* sv/bmpu_queue.sv */
module bmpu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bmpu_pkg::entry_type push_data,
   input  logic                pop,
   output bmpu_pkg::entry_type pop_data,
   output logic                empty,
   output logic                full
);
   import bmpu_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* sv/bmpu_back.sv */
module bmpu_back (
   input  logic                               clock,
   input  logic                               reset,
   input  bmpu_pkg::cfg_type                  cfg,
   input  logic                               empty,
   input  bmpu_pkg::entry_type                pop_data,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bmpu_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import bmpu_pkg::*;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  last_ff;
   logic [IDX_FULL_W-1:0] idx_full;
   logic [7:0]            red, green, blue, alpha;

   function automatic logic [7:0] pick(input logic [3:0][7:0] b, input chan_sel_type s);
      return s.present ? b[s.sel] : CHAN_ABSENT;
   endfunction

   assign pop = !empty && (!valid_ff || rsp_tready);

   always_comb begin
      idx_full = IDX_FULL_W'(pop_data.dest_row) * IDX_FULL_W'(cfg.width)
               + IDX_FULL_W'(pop_data.col);
      red      = pick(pop_data.bytes, cfg.red);
      green    = pick(pop_data.bytes, cfg.green);
      blue     = pick(pop_data.bytes, cfg.blue);
      alpha    = pick(pop_data.bytes, cfg.alpha);
      data_in  = {alpha, blue, green, red, IDX_W'(idx_full)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
         last_ff <= pop_data.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* sv/bmp_pixel_unpacker_unit.sv */
// BMP pixel array unpacker, 24 or 32 bits per pixel.
// req_*: one byte of the pixel array per transfer, in file order, row padding included.
// rsp_*: one transfer per completed pixel: destination index (top row first) and
//    red, green, blue, alpha; rsp_tlast marks the final pixel of the image.
// csr_*: register writes (format, channel masks, width, height, top_down); a write to
//    any of these restarts the stream position. Write only while the block is idle.
//    csr_ready is always high.
// Throughput: one byte per cycle while the queue is not full; a pixel leaves every 3 or 4 bytes.
// Path: a pixel's final byte transfer pushes it from the front counter stage into a
//    2-entry queue; the back stage pops it, selects channels and computes the index
//    (one multiply) into the output register, which drives rsp_tvalid.
// Reset: counters clear, queue and output empty, registers take their defaults
//    (32 bpp plain, width and height 1, bottom-up).
// Stall: while rsp_tready is low the output holds; the queue takes up to two more
//    pixels, then req_tready drops until the output drains.
module bmp_pixel_unpacker_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] data_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [23:0] pixel_index, [31:24] red, [39:32] green, [47:40] blue, [55:48] alpha
   output logic [bmpu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,  // last_pixel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bmpu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmpu_pkg::CSR_DATA_W-1:0] csr_data
);
   import bmpu_pkg::*;

   cfg_type   cfg;
   entry_type push_data;
   entry_type pop_data;
   logic      restart;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;

   bmpu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .restart   (restart),
      .cfg       (cfg)
   );

   bmpu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .restart    (restart),
      .cfg        (cfg),
      .full       (full),
      .push       (push),
      .push_data  (push_data)
   );

   bmpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty),
      .full      (full)
   );

   bmpu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .empty      (empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* sv/bmpu_checker.sv */
module bmpu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [7:0]                      req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bmpu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [bmpu_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [bmpu_pkg::CSR_DATA_W-1:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transfer dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not cleared by reset");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp transfer without a preceding req transfer");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr channel not ready");

endmodule

bind bmp_pixel_unpacker_unit bmpu_checker u_bmpu_checker (.*);
